// ===== sv/pfr_pkg.sv =====
// Shared types and constants for the page frame replacer.
package pfr_pkg;

	localparam int FRAMES_DEF = 4;
	localparam int TASK_W     = 2;
	localparam int PAGE_W     = 8;
	localparam int FOUT_W     = 2;
	localparam int USAGE_W    = 9;

	localparam logic [USAGE_W-1:0] USAGE_LOAD = 9'd255;
	localparam logic [USAGE_W-1:0] USAGE_MAX  = 9'd511;
	localparam logic [USAGE_W-1:0] USAGE_FILL = USAGE_LOAD + 9'd1;

	typedef enum logic [0:0] {
		CMD_ACCESS  = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_FREE     = 2'd1,
		ST_EVICT    = 2'd2,
		ST_RELEASED = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t              command;
		logic [TASK_W-1:0] task_id;
		logic [PAGE_W-1:0] page_number;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [FOUT_W-1:0] frame_index;
		logic [TASK_W-1:0] evicted_task;
		logic [PAGE_W-1:0] evicted_page;
	} rsp_t;

endpackage

// ===== sv/pfr_table.sv =====
// Frame table storage: owner, page and aged usage count per frame.
module pfr_table import pfr_pkg::*; #(
	parameter int FRAMES = FRAMES_DEF,
	localparam int FIDX_W = $clog2(FRAMES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               proc,
	input  status_t            status,
	input  logic [FIDX_W-1:0]  sel,
	input  logic [TASK_W-1:0]  task_id,
	input  logic [PAGE_W-1:0]  page_number,
	output logic [FRAMES-1:0]  vld,
	output logic [TASK_W-1:0]  owner[FRAMES],
	output logic [PAGE_W-1:0]  page[FRAMES],
	output logic [USAGE_W-1:0] aged[FRAMES]
);

	logic [FRAMES-1:0]  vld_q;
	logic [TASK_W-1:0]  owner_q[FRAMES];
	logic [PAGE_W-1:0]  page_q[FRAMES];
	logic [USAGE_W-1:0] usage_q[FRAMES];

	// every item ages all nonzero counts by one before anything else
	always_comb begin
		for (int f = 0; f < FRAMES; f++) begin
			aged[f] = (usage_q[f] != '0) ? usage_q[f] - 1'b1 : usage_q[f];
		end
	end

	assign vld   = vld_q;
	assign owner = owner_q;
	assign page  = page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			for (int f = 0; f < FRAMES; f++) begin
				owner_q[f] <= '0;
				page_q[f]  <= '0;
				usage_q[f] <= USAGE_LOAD;
			end
		end else if (proc) begin
			for (int f = 0; f < FRAMES; f++) begin
				if (status == ST_RELEASED) begin
					usage_q[f] <= aged[f];
					if (vld_q[f] && owner_q[f] == task_id) begin
						vld_q[f]  <= 1'b0;
						page_q[f] <= '0;
					end
				end else if (FIDX_W'(f) == sel) begin
					if (status == ST_HIT) begin
						usage_q[f] <= (aged[f] != USAGE_MAX) ? aged[f] + 1'b1 : aged[f];
					end else begin
						vld_q[f]   <= 1'b1;
						owner_q[f] <= task_id;
						page_q[f]  <= page_number;
						usage_q[f] <= USAGE_FILL;
					end
				end else begin
					usage_q[f] <= aged[f];
				end
			end
		end
	end

	a_access_maps: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && status != ST_RELEASED) |=> vld_q[$past(sel)] &&
		owner_q[$past(sel)] == $past(task_id) && page_q[$past(sel)] == $past(page_number))
		else $error("accessed frame does not hold the page");

	a_access_count: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && status != ST_RELEASED) |=> usage_q[$past(sel)] != '0)
		else $error("accessed frame has zero usage");

	a_release_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && status == ST_RELEASED) |=> $countones(vld_q) <= $past($countones(vld_q)))
		else $error("release added a frame");

	a_access_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && status != ST_RELEASED) |=> $countones(vld_q) >= $past($countones(vld_q)))
		else $error("access dropped a frame");

endmodule

// ===== sv/pfr_lookup.sv =====
// Access decision: hit match, first free frame, least-used victim search.
module pfr_lookup import pfr_pkg::*; #(
	parameter int FRAMES = FRAMES_DEF,
	localparam int FIDX_W = $clog2(FRAMES)
) (
	input  logic [FRAMES-1:0]  vld,
	input  logic [TASK_W-1:0]  owner[FRAMES],
	input  logic [PAGE_W-1:0]  page[FRAMES],
	input  logic [USAGE_W-1:0] aged[FRAMES],
	input  logic [TASK_W-1:0]  task_id,
	input  logic [PAGE_W-1:0]  page_number,
	output status_t            status,
	output logic [FIDX_W-1:0]  sel,
	output logic [TASK_W-1:0]  ev_task,
	output logic [PAGE_W-1:0]  ev_page
);

	localparam int LEAVES = 1 << FIDX_W;

	logic              hit, free;
	logic [FIDX_W-1:0] hit_idx, free_idx, min_idx;
	logic              nv[2*LEAVES];
	logic [USAGE_W-1:0] nval[2*LEAVES];
	logic [FIDX_W-1:0] nidx[2*LEAVES];

	// priority encoders, lowest index wins
	always_comb begin
		hit      = 1'b0;
		free     = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int f = FRAMES - 1; f >= 0; f--) begin
			if (vld[f] && owner[f] == task_id && page[f] == page_number) begin
				hit     = 1'b1;
				hit_idx = FIDX_W'(f);
			end
			if (!vld[f]) begin
				free     = 1'b1;
				free_idx = FIDX_W'(f);
			end
		end
	end

	// min tree over aged counts; on a tie the left (lower) index stays
	always_comb begin
		nv[0]   = 1'b0;
		nval[0] = '0;
		nidx[0] = '0;
		for (int i = 0; i < LEAVES; i++) begin
			nv[LEAVES+i]   = (i < FRAMES);
			nval[LEAVES+i] = (i < FRAMES) ? aged[i % FRAMES] : '0;
			nidx[LEAVES+i] = FIDX_W'(i);
		end
		for (int n = LEAVES - 1; n >= 1; n--) begin
			if (!nv[2*n] || (nv[2*n+1] && nval[2*n+1] < nval[2*n])) begin
				nv[n]   = nv[2*n+1];
				nval[n] = nval[2*n+1];
				nidx[n] = nidx[2*n+1];
			end else begin
				nv[n]   = nv[2*n];
				nval[n] = nval[2*n];
				nidx[n] = nidx[2*n];
			end
		end
		min_idx = nidx[1];
	end

	always_comb begin
		if (hit) begin
			status = ST_HIT;
			sel    = hit_idx;
		end else if (free) begin
			status = ST_FREE;
			sel    = free_idx;
		end else begin
			status = ST_EVICT;
			sel    = min_idx;
		end
		ev_task = owner[min_idx];
		ev_page = page[min_idx];
	end

endmodule

// ===== sv/page_frame_replacer_top.sv =====
// Top level of the page frame replacer: input register, lookup, result register.
//
//  channel | signals                    | payload
//  --------+----------------------------+--------------------------------------
//  request | req_valid / req_ready      | req: command, task_id, page_number
//  result  | rsp_valid / rsp_ready      | rsp: status, frame_index, evicted_*
//
// One item per cycle sustained while the result is taken; a request passes through
// the request register, then the match/min search over the frame table into
// the result register, which also writes the table.
// Reset leaves every frame free with usage 255; no warm-up.
// A stalled result holds the request register; req_ready drops only when both
// the request register and the result register are full.
module page_frame_replacer_top import pfr_pkg::*; #(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int FIDX_W = $clog2(FRAMES);

	logic               vld_s1;
	req_t               req_s1;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic               advance, proc;
	logic [FRAMES-1:0]  vld;
	logic [TASK_W-1:0]  owner[FRAMES];
	logic [PAGE_W-1:0]  page[FRAMES];
	logic [USAGE_W-1:0] aged[FRAMES];
	status_t            lk_status, status;
	logic [FIDX_W-1:0]  sel;
	logic [TASK_W-1:0]  ev_task;
	logic [PAGE_W-1:0]  ev_page;
	rsp_t               result;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = !vld_s1 || advance;
	assign proc      = vld_s1 && advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	pfr_lookup #(.FRAMES(FRAMES)) u_lookup (
		.vld         (vld),
		.owner       (owner),
		.page        (page),
		.aged        (aged),
		.task_id     (req_s1.task_id),
		.page_number (req_s1.page_number),
		.status      (lk_status),
		.sel         (sel),
		.ev_task     (ev_task),
		.ev_page     (ev_page)
	);

	assign status = (req_s1.command == CMD_RELEASE) ? ST_RELEASED : lk_status;

	pfr_table #(.FRAMES(FRAMES)) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.proc        (proc),
		.status      (status),
		.sel         (sel),
		.task_id     (req_s1.task_id),
		.page_number (req_s1.page_number),
		.vld         (vld),
		.owner       (owner),
		.page        (page),
		.aged        (aged)
	);

	always_comb begin
		result.status       = status;
		result.frame_index  = '0;
		result.evicted_task = '0;
		result.evicted_page = '0;
		if (status != ST_RELEASED)
			result.frame_index = FOUT_W'(sel);
		if (status == ST_EVICT) begin
			result.evicted_task = ev_task;
			result.evicted_page = ev_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready)
				vld_s1 <= req_valid;
			if (advance)
				rsp_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req;
		if (proc)
			rsp_q <= result;
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && rsp_valid_q && !rsp_ready) |-> !req_ready)
		else $error("request taken with pipeline full");

	a_release_fields: assert property (@(posedge clk) disable iff (!arst_n)
		proc && status == ST_RELEASED |=> rsp_q.frame_index == '0 &&
		rsp_q.evicted_task == '0 && rsp_q.evicted_page == '0)
		else $error("release result carries frame data");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && status == ST_EVICT) |-> vld == '1)
		else $error("eviction with a free frame");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for page_frame_replacer_top: LFU frame table predictor and flow control.
`timescale 1ns / 1ps

module tb;
	import pfr_pkg::*;

	localparam int NFRAMES      = FRAMES_DEF;
	localparam int RANDOM_ITEMS = 450;
	localparam int PHASE1_AT    = 160;
	localparam int PHASE2_AT    = 320;
	localparam int HOLD_AT      = 100;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 50000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	page_frame_replacer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predicted frame table; owner 0 = free, else task + 1
	logic [2:0]         tbl_owner [NFRAMES];
	logic [PAGE_W-1:0]  tbl_page  [NFRAMES];
	logic [USAGE_W-1:0] tbl_usage [NFRAMES];

	req_t access_queue [$];
	rsp_t due_results  [$];

	int sent_cnt = 0;
	int errors = 0;
	int cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int n_hit = 0, n_free = 0, n_evict = 0, n_release = 0;
	rsp_t want;

	wire [1:0] flow_phase = (sent_cnt < PHASE1_AT) ? 2'd0 : (sent_cnt < PHASE2_AT) ? 2'd1 : 2'd2;
	wire [6:0] send_idle_pct = (flow_phase == 2'd0) ? 7'd13 : (flow_phase == 2'd1) ? 7'd46 : 7'd0;
	wire [6:0] recv_idle_pct = (flow_phase == 2'd0) ? 7'd46 : (flow_phase == 2'd1) ? 7'd13 : 7'd0;

	// Ages the table, then applies one access or release; returns the result it yields.
	function automatic rsp_t lfu_lookup(req_t r);
		rsp_t res;
		logic [2:0] tag;
		int slot;
		bit found;
		res = '0;
		tag = {1'b0, r.task_id} + 3'd1;
		slot = 0;
		found = 1'b0;
		for (int i = 0; i < NFRAMES; i++)
			if (tbl_usage[i] != '0)
				tbl_usage[i] = tbl_usage[i] - 1'b1;
		if (r.command == CMD_RELEASE) begin
			for (int i = 0; i < NFRAMES; i++) begin
				if (tbl_owner[i] == tag) begin
					tbl_owner[i] = 3'd0;
					tbl_page[i] = '0;
				end
			end
			res.status = ST_RELEASED;
			return res;
		end
		for (int i = 0; i < NFRAMES; i++) begin
			if (!found && tbl_owner[i] == tag && tbl_page[i] == r.page_number) begin
				slot = i;
				found = 1'b1;
			end
		end
		if (found) begin
			res.status = ST_HIT;
		end else begin
			for (int i = 0; i < NFRAMES; i++) begin
				if (!found && tbl_owner[i] == 3'd0) begin
					slot = i;
					found = 1'b1;
				end
			end
			if (found) begin
				res.status = ST_FREE;
			end else begin
				// no free frame: smallest count loses, ties to lowest index
				for (int i = 1; i < NFRAMES; i++)
					if (tbl_usage[i] < tbl_usage[slot])
						slot = i;
				res.status = ST_EVICT;
				res.evicted_task = TASK_W'(tbl_owner[slot] - 3'd1);
				res.evicted_page = tbl_page[slot];
			end
			tbl_owner[slot] = tag;
			tbl_page[slot] = r.page_number;
			tbl_usage[slot] = USAGE_LOAD;
		end
		if (tbl_usage[slot] < USAGE_MAX)
			tbl_usage[slot] = tbl_usage[slot] + 1'b1;
		res.frame_index = FOUT_W'(slot);
		return res;
	endfunction

	task automatic add_item(cmd_t c, int t, int p);
		req_t r;
		r.command = c;
		r.task_id = TASK_W'(t);
		r.page_number = PAGE_W'(p);
		access_queue.push_back(r);
	endtask

	task automatic field_check(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready) begin
				due_results.push_back(lfu_lookup(req));
				sent_cnt <= sent_cnt + 1;
			end
			if (!req_valid || req_ready) begin
				if (access_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= access_queue.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h", $time, rsp);
					errors++;
				end else begin
					want = due_results.pop_front();
					field_check("status", 8'(want.status), 8'(rsp.status));
					field_check("frame_index", 8'(want.frame_index), 8'(rsp.frame_index));
					field_check("evicted_task", 8'(want.evicted_task), 8'(rsp.evicted_task));
					field_check("evicted_page", want.evicted_page, rsp.evicted_page);
					case (want.status)
						ST_HIT:   n_hit++;
						ST_FREE:  n_free++;
						ST_EVICT: n_evict++;
						default:  n_release++;
					endcase
				end
			end
			if (hold_left != 0) begin
				rsp_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && sent_cnt >= HOLD_AT) begin
				// long stall so both internal registers fill and req_ready drops
				rsp_ready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int ws_base [4];
		int mode;
		int t;
		for (int i = 0; i < NFRAMES; i++) begin
			tbl_owner[i] = 3'd0;
			tbl_page[i] = '0;
			tbl_usage[i] = USAGE_LOAD;
		end

		// directed: release of an idle task, fill, hits, same page other task, evictions
		add_item(CMD_RELEASE, 2, 8'h33);
		add_item(CMD_ACCESS, 0, 8'h00);
		add_item(CMD_ACCESS, 1, 8'hFF);
		add_item(CMD_ACCESS, 0, 8'h00);
		add_item(CMD_ACCESS, 2, 8'h55);
		add_item(CMD_ACCESS, 3, 8'hAA);
		add_item(CMD_ACCESS, 3, 8'hAA);
		add_item(CMD_ACCESS, 1, 8'h00);
		add_item(CMD_ACCESS, 2, 8'h0F);
		add_item(CMD_ACCESS, 0, 8'hF0);
		add_item(CMD_ACCESS, 1, 8'hFF);
		add_item(CMD_RELEASE, 0, 8'hFF);
		add_item(CMD_RELEASE, 1, 8'h00);
		add_item(CMD_ACCESS, 0, 8'h01);
		add_item(CMD_ACCESS, 1, 8'h80);
		add_item(CMD_RELEASE, 3, 8'h00);
		add_item(CMD_RELEASE, 3, 8'h00);
		add_item(CMD_ACCESS, 3, 8'h7F);
		add_item(CMD_ACCESS, 2, 8'h0F);
		add_item(CMD_ACCESS, 3, 8'hFE);
		add_item(CMD_ACCESS, 2, 8'h01);
		add_item(CMD_ACCESS, 3, 8'h7F);

		// random: per-task working sets of three pages, some releases and noise
		for (int i = 0; i < 4; i++)
			ws_base[i] = $urandom_range(255);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			mode = $urandom_range(99);
			t = $urandom_range(3);
			if ($urandom_range(29) == 0)
				ws_base[t] = $urandom_range(255);
			if (mode < 8)
				add_item(CMD_RELEASE, t, $urandom_range(255));
			else if (mode < 85)
				add_item(CMD_ACCESS, t, (ws_base[t] + $urandom_range(2)) & 8'hFF);
			else
				add_item(CMD_ACCESS, t, $urandom_range(255));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (access_queue.size() != 0 || req_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (due_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, due_results.size());
			errors++;
		end
		$display("Ran %0d requests over three flow-control phases plus one long output stall.",
			sent_cnt);
		$display("Saw %0d hits, %0d free-frame loads, %0d evictions, %0d releases; %0d errors.",
			n_hit, n_free, n_evict, n_release, errors);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
